// File: design/vrm_pkg.sv
// Types, codes and widths shared by the vacuum robot motion controller.
package vrm_pkg;

	localparam int TICK_COUNT_WIDTH = 8;
	localparam int CFG_W = 8;
	localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;
	localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

	typedef enum logic [2:0] {
		MODE_MOVING  = 3'd0,
		MODE_TURNING = 3'd1,
		MODE_BACKING = 3'd2,
		MODE_DUST    = 3'd3,
		MODE_PAUSED  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		MOT_FWD   = 3'd0,
		MOT_LEFT  = 3'd1,
		MOT_RIGHT = 3'd2,
		MOT_BACK  = 3'd3,
		MOT_STOP  = 3'd4
	} motor_t;

	typedef enum logic [1:0] {
		CLN_OFF   = 2'd0,
		CLN_ON    = 2'd1,
		CLN_BOOST = 2'd2
	} cleaner_t;

	typedef enum logic [1:0] {
		CFG_DUST_CLEAN = 2'd0,
		CFG_BACKWARD   = 2'd1,
		CFG_TURN       = 2'd2,
		CFG_PAUSE      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic front_blocked;
		logic left_blocked;
		logic right_blocked;
		logic dust_seen;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] motor_command;
		logic [1:0] cleaner_command;
		logic [2:0] current_mode;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] dust_clean_ticks;
		logic [CFG_W-1:0] backward_ticks;
		logic [CFG_W-1:0] turn_ticks;
		logic [CFG_W-1:0] pause_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t                       mode;
		logic [TICK_COUNT_WIDTH-1:0] ticks;
		logic [CFG_W-1:0]            backing_left;
		logic [CFG_W-1:0]            dust_left;
		motor_t                      motor;
		cleaner_t                    cleaner;
	} state_t;

endpackage

// File: design/vrm_step.sv
// Next-state logic for one control tick of the motion controller.
module vrm_step (
	input  vrm_pkg::state_t   cur,
	input  vrm_pkg::cfg_t     cfg,
	input  vrm_pkg::in_beat_t sens,
	output vrm_pkg::state_t   nxt
);
	import vrm_pkg::*;

	logic [TICK_COUNT_WIDTH-1:0] ticks_inc;
	logic [CFG_W-1:0]            back_dec;
	logic [CFG_W-1:0]            dust_dec;
	logic                        turn_done;
	logic                        pause_done;

	assign ticks_inc  = (cur.ticks == TICK_MAX) ? cur.ticks
	                                            : cur.ticks + TICK_COUNT_WIDTH'(1);
	// countdowns stick at zero, so a zero load ends after one tick
	assign back_dec   = (cur.backing_left == '0) ? '0 : cur.backing_left - CFG_W'(1);
	assign dust_dec   = (cur.dust_left == '0) ? '0 : cur.dust_left - CFG_W'(1);
	assign turn_done  = CMP_W'(ticks_inc) >= CMP_W'(cfg.turn_ticks);
	assign pause_done = CMP_W'(ticks_inc) >= CMP_W'(cfg.pause_ticks);

	always_comb begin
		nxt       = cur;
		nxt.ticks = ticks_inc;
		unique case (cur.mode)
			MODE_MOVING: begin
				nxt.motor   = MOT_FWD;
				nxt.cleaner = CLN_ON;
				if (sens.dust_seen) begin
					nxt.dust_left = cfg.dust_clean_ticks;
					nxt.mode      = MODE_DUST;
					nxt.ticks     = '0;
				end else if (sens.front_blocked) begin
					nxt.mode  = MODE_TURNING;
					nxt.ticks = '0;
				end
			end
			MODE_TURNING: begin
				nxt.cleaner = CLN_ON;
				if (sens.front_blocked && sens.left_blocked && sens.right_blocked) begin
					nxt.backing_left = cfg.backward_ticks;
					nxt.mode         = MODE_BACKING;
					nxt.ticks        = '0;
				end else if (sens.left_blocked && sens.right_blocked) begin
					// sides only: motor is held
					nxt.mode  = MODE_PAUSED;
					nxt.ticks = '0;
				end else begin
					nxt.motor = sens.left_blocked ? MOT_RIGHT : MOT_LEFT;
					if (turn_done) begin
						nxt.mode  = MODE_MOVING;
						nxt.ticks = '0;
					end
				end
			end
			MODE_BACKING: begin
				nxt.motor        = MOT_BACK;
				nxt.cleaner      = CLN_ON;
				nxt.backing_left = back_dec;
				if (back_dec == '0) begin
					nxt.mode  = MODE_TURNING;
					nxt.ticks = '0;
				end
			end
			MODE_DUST: begin
				nxt.motor     = MOT_STOP;
				nxt.cleaner   = CLN_BOOST;
				nxt.dust_left = dust_dec;
				if (dust_dec == '0) begin
					nxt.mode  = MODE_MOVING;
					nxt.ticks = '0;
				end
			end
			MODE_PAUSED: begin
				nxt.motor   = MOT_STOP;
				nxt.cleaner = CLN_ON;
				if (pause_done) begin
					nxt.backing_left = cfg.backward_ticks;
					nxt.mode         = MODE_BACKING;
					nxt.ticks        = '0;
				end
			end
			default: begin
				// unused codes only count ticks
			end
		endcase
	end

endmodule

// File: design/vacuum_robot_motion_fsm_core.sv
// Top level of the vacuum robot motion controller: state, config and output buffering.
//
// One input beat is one control tick carrying four sensor bits (front, left,
// right, dust). Each accepted beat yields exactly one output beat with the
// motor command, cleaner command and the mode after the tick.
// Channels use valid/stall; a beat moves on an edge with valid high, stall low.
// The result is registered into the output register, or the skid register while
// the output is stalled. Throughput: one beat per cycle while in_stall is low;
// the next-state logic is a single pass from the state registers into them.
// A two-entry output buffer (output register plus skid register) lets a beat
// be accepted while a result waits; in_stall rises only once the skid entry
// holds a beat, and the stalled output beat holds steady.
// Config writes (cfg_we, cfg_index, cfg_data) land the same edge; write only
// while idle.
// Reset: mode moving, tick count and countdowns zero, motor stop, cleaner
// off, registers at their defaults (5, 3, 2, 3), both buffer entries empty.
module vacuum_robot_motion_fsm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vrm_pkg::in_beat_t  in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output vrm_pkg::out_beat_t out_beat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import vrm_pkg::*;

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    state_nxt;
	out_beat_t out_q;
	out_beat_t skid_q;
	out_beat_t res;
	logic      out_valid_q;
	logic      skid_valid_q;
	logic      in_acc;
	logic      out_free;

	vrm_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.sens (in_beat),
		.nxt  (state_nxt)
	);

	assign res.motor_command   = state_nxt.motor;
	assign res.cleaner_command = state_nxt.cleaner;
	assign res.current_mode    = state_nxt.mode;

	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dust_clean_ticks <= 8'd5;
			cfg_q.backward_ticks   <= 8'd3;
			cfg_q.turn_ticks       <= 8'd2;
			cfg_q.pause_ticks      <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DUST_CLEAN: cfg_q.dust_clean_ticks <= cfg_data;
				CFG_BACKWARD:   cfg_q.backward_ticks   <= cfg_data;
				CFG_TURN:       cfg_q.turn_ticks       <= cfg_data;
				CFG_PAUSE:      cfg_q.pause_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= MODE_MOVING;
			state_q.ticks        <= '0;
			state_q.backing_left <= '0;
			state_q.dust_left    <= '0;
			state_q.motor        <= MOT_STOP;
			state_q.cleaner      <= CLN_OFF;
			out_valid_q          <= 1'b0;
			skid_valid_q         <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_acc;
				end
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

endmodule

// File: design/vrm_checker.sv
// Port-level checks for the motion controller, bound to the top level.
module vrm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input vrm_pkg::out_beat_t out_beat
);
	import vrm_pkg::*;

	// a stalled output beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// with the output empty, an accepted beat shows up on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> out_valid)
		else $error("accepted beat not delivered after one cycle");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_beat))
		else $error("stalled output beat changed");

	// every tick drives the cleaner, and codes stay within their lists
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		out_beat.cleaner_command != CLN_OFF && out_beat.cleaner_command != 2'd3 &&
		out_beat.motor_command <= MOT_STOP && out_beat.current_mode <= MODE_PAUSED)
		else $error("command or mode code out of range");

endmodule

bind vacuum_robot_motion_fsm_core vrm_checker u_vrm_checker (.*);

// File: tb/sv/vrm_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the motion controller: mirrors the mode machine and checks each command beat.
package vrm_tb_pkg;
	import vrm_pkg::*;

	class motion_scoreboard;
		logic [CFG_W-1:0]            dust_clean_ticks;
		logic [CFG_W-1:0]            backward_ticks;
		logic [CFG_W-1:0]            turn_ticks;
		logic [CFG_W-1:0]            pause_ticks;
		mode_t                       mode;
		logic [TICK_COUNT_WIDTH-1:0] ticks;
		logic [CFG_W-1:0]            backing_left;
		logic [CFG_W-1:0]            dust_left;
		motor_t                      motor;
		cleaner_t                    cleaner;
		out_beat_t                   expected_cmds[$];
		int                          mismatches;
		int                          ticks_seen;
		int                          results_seen;
		int                          mode_hits[5];

		function new();
			dust_clean_ticks = 8'd5;
			backward_ticks   = 8'd3;
			turn_ticks       = 8'd2;
			pause_ticks      = 8'd3;
			mode             = MODE_MOVING;
			ticks            = '0;
			backing_left     = '0;
			dust_left        = '0;
			motor            = MOT_STOP;
			cleaner          = CLN_OFF;
			mismatches       = 0;
			ticks_seen       = 0;
			results_seen     = 0;
			foreach (mode_hits[i]) mode_hits[i] = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_DUST_CLEAN: dust_clean_ticks = val;
				CFG_BACKWARD:   backward_ticks = val;
				CFG_TURN:       turn_ticks = val;
				CFG_PAUSE:      pause_ticks = val;
				default: ;
			endcase
		endfunction

		function void enter(mode_t m);
			mode  = m;
			ticks = '0;
		endfunction

		// countdowns stop at zero, so a load of zero ends after one tick
		function logic [CFG_W-1:0] count_down(logic [CFG_W-1:0] v);
			return (v == '0) ? '0 : v - 1'b1;
		endfunction

		function void note_tick(in_beat_t b);
			out_beat_t e;
			ticks_seen++;
			if (ticks != TICK_MAX) ticks++;
			case (mode)
				MODE_MOVING: begin
					motor   = MOT_FWD;
					cleaner = CLN_ON;
					if (b.dust_seen) begin
						dust_left = dust_clean_ticks;
						enter(MODE_DUST);
					end else if (b.front_blocked) begin
						enter(MODE_TURNING);
					end
				end
				MODE_TURNING: begin
					cleaner = CLN_ON;
					if (b.front_blocked && b.left_blocked && b.right_blocked) begin
						backing_left = backward_ticks;
						enter(MODE_BACKING);
					end else if (b.left_blocked && b.right_blocked) begin
						// motor keeps its last command into the pause
						enter(MODE_PAUSED);
					end else begin
						motor = b.left_blocked ? MOT_RIGHT : MOT_LEFT;
						if (ticks >= turn_ticks) enter(MODE_MOVING);
					end
				end
				MODE_BACKING: begin
					motor        = MOT_BACK;
					cleaner      = CLN_ON;
					backing_left = count_down(backing_left);
					if (backing_left == '0) enter(MODE_TURNING);
				end
				MODE_DUST: begin
					motor     = MOT_STOP;
					cleaner   = CLN_BOOST;
					dust_left = count_down(dust_left);
					if (dust_left == '0) enter(MODE_MOVING);
				end
				MODE_PAUSED: begin
					motor   = MOT_STOP;
					cleaner = CLN_ON;
					if (ticks >= pause_ticks) begin
						backing_left = backward_ticks;
						enter(MODE_BACKING);
					end
				end
				default: ;
			endcase
			e.motor_command   = motor;
			e.cleaner_command = cleaner;
			e.current_mode    = mode;
			expected_cmds.push_back(e);
		endfunction

		function void check_command(out_beat_t got);
			out_beat_t e;
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected command beat: motor %0d cleaner %0d mode %0d",
						got.motor_command, got.cleaner_command, got.current_mode);
				return;
			end
			e = expected_cmds.pop_front();
			results_seen++;
			if (e.current_mode < 5) mode_hits[e.current_mode]++;
			if (got.motor_command !== e.motor_command ||
				got.cleaner_command !== e.cleaner_command ||
				got.current_mode !== e.current_mode) begin
				mismatches++;
				if (mismatches <= 10)
					$display("beat %0d: expected motor %0d cleaner %0d mode %0d, got %0d %0d %0d",
						results_seen, e.motor_command, e.cleaner_command, e.current_mode,
						got.motor_command, got.cleaner_command, got.current_mode);
			end
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

endpackage

// File: tb/sv/tb_vacuum_robot_motion_fsm_core.sv
`timescale 1ns / 1ps
// Testbench for the motion controller: directed and random sensor ticks under mixed back-pressure.
module tb_vacuum_robot_motion_fsm_core;
	import vrm_pkg::*;
	import vrm_tb_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_beat;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_beat;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	int send_idle_pct;
	int recv_stall_pct;
	int settings_used;
	motion_scoreboard sb;

	// f l r d per tick; first tick in the top nibble
	localparam logic [22:0][3:0] DIRECTED = {
		4'b0000,                                  // moving, forward
		4'b1001,                                  // dust wins over front
		4'b1111, 4'b1111, 4'b1111, 4'b1111, 4'b1111, // dust countdown
		4'b1000,                                  // front -> turning
		4'b0100,                                  // left blocked: turn right
		4'b0000,                                  // turn left, turn done
		4'b1000,                                  // front -> turning
		4'b0110,                                  // sides blocked: pause
		4'b0000, 4'b0000, 4'b0000,                // pause -> backing
		4'b0000, 4'b0000, 4'b0000,                // backing -> turning
		4'b1110,                                  // all blocked: back up
		4'b0000, 4'b0000, 4'b0000,
		4'b0010                                   // right blocked: turn left
	};

	vacuum_robot_motion_fsm_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("vacuum_robot_motion_fsm_core: mismatch");
		$finish;
	end

	// result side: sample the beat, then pick the next stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_command(out_beat);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_tick(input in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_tick(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] dust_t, back_t, turn_t, pause_t);
		cfg_idx_t   idx [4];
		logic [7:0] val [4];
		idx = '{CFG_DUST_CLEAN, CFG_BACKWARD, CFG_TURN, CFG_PAUSE};
		val = '{dust_t, back_t, turn_t, pause_t};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// mostly obstacle-heavy ticks so turns, pauses and back-ups happen often
	function automatic in_beat_t random_tick();
		in_beat_t   b;
		logic [3:0] bits;
		if ($urandom_range(3) == 0) begin
			bits = 4'($urandom_range(15));
			b = bits;
		end else begin
			b.dust_seen     = ($urandom_range(99) < 8);
			b.front_blocked = ($urandom_range(99) < 45);
			b.left_blocked  = ($urandom_range(99) < 55);
			b.right_blocked = ($urandom_range(99) < 55);
		end
		return b;
	endfunction

	task automatic run_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			send_tick(random_tick());
			if ($urandom_range(199) == 0) drain();
		end
		drain();
		repeat (2) @(posedge clk);
	endtask

	initial begin
		sb = new();
		settings_used  = 1;
		send_idle_pct  = 38;
		recv_stall_pct = 78;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_beat   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_DUST_CLEAN;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 22; i >= 0; i--) send_tick(in_beat_t'(DIRECTED[i]));
		drain();
		repeat (2) @(posedge clk);

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle_pct  = 38;
				recv_stall_pct = 78;
			end else if (p < 4) begin
				send_idle_pct  = 78;
				recv_stall_pct = 38;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			case (p)
				0: program_regs(8'd0, 8'd0, 8'd0, 8'd0);
				1: program_regs(8'd255, 8'd255, 8'd255, 8'd255);
				2: program_regs(8'd1, 8'd2, 8'd1, 8'd1);
				3: program_regs(8'd5, 8'd3, 8'd2, 8'd3);
				4: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				default: program_regs(8'($urandom_range(7)), 8'($urandom_range(7)),
					8'($urandom_range(7)), 8'($urandom_range(7)));
			endcase
			run_ticks((p == 1) ? 300 : 200);
		end

		repeat (4) @(posedge clk);
		$display("covered %0d ticks (%0d results) over %0d register settings and three idle mixes",
			sb.ticks_seen, sb.results_seen, settings_used);
		$display("mode occupancy: moving %0d, turning %0d, backing %0d, dust %0d, paused %0d",
			sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
			sb.mode_hits[4]);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("vacuum_robot_motion_fsm_core: match");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
			$display("vacuum_robot_motion_fsm_core: mismatch");
		end
		$finish;
	end

endmodule

// File: vacuum_robot_motion_fsm_core.f
design/vrm_pkg.sv
design/vrm_step.sv
design/vacuum_robot_motion_fsm_core.sv
design/vrm_checker.sv
tb/sv/vrm_tb_pkg.sv
tb/sv/tb_vacuum_robot_motion_fsm_core.sv
